@@ src/cbt_pkg.sv @@
`timescale 1ns / 1ps

package cbt_pkg;

  localparam int DEF_SEGMENTS = 20;

  localparam int CoordW = 16;
  localparam int WeightW = 16;

  // Q1.15 weight for 1.0
  localparam longint OneQ15 = 32768;

  typedef struct packed {
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] start_z;
    logic signed [CoordW-1:0] ctrl_one_x;
    logic signed [CoordW-1:0] ctrl_one_y;
    logic signed [CoordW-1:0] ctrl_one_z;
    logic signed [CoordW-1:0] ctrl_two_x;
    logic signed [CoordW-1:0] ctrl_two_y;
    logic signed [CoordW-1:0] ctrl_two_z;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic signed [CoordW-1:0] end_z;
  } curve_t;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
    logic                     final_point;
  } point_t;

  typedef struct packed {
    logic [WeightW-1:0] w0;
    logic [WeightW-1:0] w1;
    logic [WeightW-1:0] w2;
    logic [WeightW-1:0] w3;
  } weights_t;

  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

endpackage

@@ src/cubic_bezier_tessellator.sv @@
`timescale 1ns / 1ps
// channel   direction  payload   handshake
// curve     in         curve_t   curve_valid / curve_stall
// point     out        point_t   point_valid / point_stall
//
// each curve yields SEGMENTS+1 points, one per cycle unless point_stall holds a waiting point
// the step counter in the sequencer sets the point count; the next curve is taken as
// the last point of the current one issues
// from curve transfer to first point: held curve, then table, multiply, pair add, sum stages
// rst clears the sequencer and all valid bits; no clearing pass
// point_stall on a waiting point freezes every stage at once, so nothing is lost or repeated

module cubic_bezier_tessellator
  import cbt_pkg::*;
#(
  parameter int SEGMENTS = DEF_SEGMENTS
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   curve_valid,
  output logic   curve_stall,
  input  curve_t curve,
  output logic   point_valid,
  input  logic   point_stall,
  output point_t point
);

  logic     adv;
  tag_t     s1_tag, s2_tag, s3_tag, s4_tag;
  weights_t s1_w;
  curve_t   s1_curve;

  assign adv = !(point_stall && s4_tag.valid);

  cbt_seq #(
    .SEGMENTS(SEGMENTS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .curve_valid(curve_valid),
    .curve_stall(curve_stall),
    .curve      (curve),
    .s1_tag     (s1_tag),
    .s1_w       (s1_w),
    .s1_curve   (s1_curve)
  );

  cbt_lane u_lane_x (
    .clk  (clk),
    .adv  (adv),
    .w    (s1_w),
    .c0   (s1_curve.start_x),
    .c1   (s1_curve.ctrl_one_x),
    .c2   (s1_curve.ctrl_two_x),
    .c3   (s1_curve.end_x),
    .coord(point.point_x)
  );

  cbt_lane u_lane_y (
    .clk  (clk),
    .adv  (adv),
    .w    (s1_w),
    .c0   (s1_curve.start_y),
    .c1   (s1_curve.ctrl_one_y),
    .c2   (s1_curve.ctrl_two_y),
    .c3   (s1_curve.end_y),
    .coord(point.point_y)
  );

  cbt_lane u_lane_z (
    .clk  (clk),
    .adv  (adv),
    .w    (s1_w),
    .c0   (s1_curve.start_z),
    .c1   (s1_curve.ctrl_one_z),
    .c2   (s1_curve.ctrl_two_z),
    .c3   (s1_curve.end_z),
    .coord(point.point_z)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_tag <= '0;
      s3_tag <= '0;
      s4_tag <= '0;
    end else if (adv) begin
      s2_tag <= s1_tag;
      s3_tag <= s2_tag;
      s4_tag <= s3_tag;
    end
  end

  assign point_valid       = s4_tag.valid;
  assign point.final_point = s4_tag.last;

endmodule

@@ src/cbt_seq.sv @@
`timescale 1ns / 1ps

module cbt_seq
  import cbt_pkg::*;
#(
  parameter int SEGMENTS = DEF_SEGMENTS
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     adv,
  input  logic     curve_valid,
  output logic     curve_stall,
  input  curve_t   curve,
  output tag_t     s1_tag,
  output weights_t s1_w,
  output curve_t   s1_curve
);

  localparam int IdxW = $clog2(SEGMENTS + 1);
  localparam longint Den = longint'(SEGMENTS) * SEGMENTS * SEGMENTS;

  weights_t wtab [SEGMENTS+1];

  // bernstein weights per step, rounded half up at elaboration
  for (genvar g = 0; g <= SEGMENTS; g++) begin : g_wtab
    localparam longint Ti = g;
    localparam longint Ui = SEGMENTS - g;
    localparam longint W0 = (Ui * Ui * Ui * OneQ15 + Den / 2) / Den;
    localparam longint W1 = (3 * Ti * Ui * Ui * OneQ15 + Den / 2) / Den;
    localparam longint W2 = (3 * Ti * Ti * Ui * OneQ15 + Den / 2) / Den;
    localparam longint W3 = (Ti * Ti * Ti * OneQ15 + Den / 2) / Den;
    assign wtab[g].w0 = WeightW'(W0);
    assign wtab[g].w1 = WeightW'(W1);
    assign wtab[g].w2 = WeightW'(W2);
    assign wtab[g].w3 = WeightW'(W3);
  end

  logic            busy;
  logic [IdxW-1:0] idx;
  curve_t          held;
  logic            at_last;
  logic            take;

  assign at_last     = (idx == IdxW'(SEGMENTS));
  // a new curve loads as the last point of the current one issues
  assign curve_stall = busy && !(adv && at_last);
  assign take        = curve_valid && !curve_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else begin
      if (take) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (busy && adv) begin
        if (at_last) begin
          busy <= 1'b0;
        end else begin
          idx <= idx + IdxW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held <= curve;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag <= '0;
    end else if (adv) begin
      s1_tag.valid <= busy;
      s1_tag.last  <= at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_w     <= wtab[idx];
      s1_curve <= held;
    end
  end

endmodule

@@ src/cbt_lane.sv @@
`timescale 1ns / 1ps

module cbt_lane
  import cbt_pkg::*;
(
  input  logic                     clk,
  input  logic                     adv,
  input  weights_t                 w,
  input  logic signed [CoordW-1:0] c0,
  input  logic signed [CoordW-1:0] c1,
  input  logic signed [CoordW-1:0] c2,
  input  logic signed [CoordW-1:0] c3,
  output logic signed [CoordW-1:0] coord
);

  localparam int ProdW = WeightW + 1 + CoordW;
  localparam int PairW = ProdW + 1;
  localparam int SumW  = ProdW + 2;
  localparam int QW    = SumW - 15;

  logic signed [WeightW:0] ws0, ws1, ws2, ws3;
  logic signed [ProdW-1:0] p0, p1, p2, p3;
  logic signed [PairW-1:0] s01, s23;
  logic signed [SumW-1:0]  sum, rnd;
  logic signed [QW-1:0]    q;
  logic signed [CoordW-1:0] sat;

  assign ws0 = signed'({1'b0, w.w0});
  assign ws1 = signed'({1'b0, w.w1});
  assign ws2 = signed'({1'b0, w.w2});
  assign ws3 = signed'({1'b0, w.w3});

  always_ff @(posedge clk) begin
    if (adv) begin
      p0 <= ws0 * c0;
      p1 <= ws1 * c1;
      p2 <= ws2 * c2;
      p3 <= ws3 * c3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s01 <= PairW'(p0) + PairW'(p1);
      s23 <= PairW'(p2) + PairW'(p3);
    end
  end

  // q5.27 to q4.12, round half up, then clamp
  assign sum = SumW'(s01) + SumW'(s23);
  assign rnd = sum + SumW'(16384);
  assign q   = rnd[SumW-1:15];

  always_comb begin
    if (q > QW'(32767)) begin
      sat = 16'sh7fff;
    end else if (q < -QW'(32768)) begin
      sat = 16'sh8000;
    end else begin
      sat = q[CoordW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      coord <= sat;
    end
  end

endmodule

@@ src/cbt_checker.sv @@
`timescale 1ns / 1ps

module cbt_checker
  import cbt_pkg::*;
#(
  parameter int SEGMENTS = DEF_SEGMENTS
) (
  input logic   clk,
  input logic   rst,
  input logic   curve_valid,
  input logic   curve_stall,
  input logic   point_valid,
  input logic   point_stall,
  input point_t point
);

  // a stalled point holds until its transfer
  a_point_hold: assert property (@(posedge clk) disable iff (rst)
    point_valid && point_stall |=> point_valid && $stable(point))
    else $error("stalled point changed");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !point_valid)
    else $error("point valid right after reset");

  // the point after a final one starts a new curve, so it is never final
  a_final_single: assert property (@(posedge clk) disable iff (rst)
    point_valid && !point_stall && point.final_point |=> !(point_valid && point.final_point))
    else $error("two final points in a row");

  // with the output side free the curve side cannot deadlock
  a_no_deadlock: assert property (@(posedge clk) disable iff (rst)
    not ((curve_valid && curve_stall && !point_stall) [*SEGMENTS+2]))
    else $error("curve side deadlocked");

endmodule

bind cubic_bezier_tessellator cbt_checker #(
  .SEGMENTS(SEGMENTS)
) u_chk (
  .clk        (clk),
  .rst        (rst),
  .curve_valid(curve_valid),
  .curve_stall(curve_stall),
  .point_valid(point_valid),
  .point_stall(point_stall),
  .point      (point)
);

@@ verif/tb_cubic_bezier_tessellator.sv @@
`timescale 1ns / 1ps

module tb_cubic_bezier_tessellator;
  import cbt_pkg::*;

  localparam int SEGS = DEF_SEGMENTS;
  localparam int RANDOM_PER_PHASE = 90;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    curve_t c;
    bit     typed;
    point_t first_pt;
    point_t last_pt;
  } bezier_row_t;

  // control points packed as {P0, P1, P2, P3}, each {x, y, z}
  bezier_row_t directed_rows [15] = '{
    '{{48'h0000_0000_0000, 48'h0000_0000_0000, 48'h0000_0000_0000, 48'h0000_0000_0000},
      1'b1, {48'h0000_0000_0000, 1'b0}, {48'h0000_0000_0000, 1'b1}},
    '{{48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff},
      1'b1, {48'h7fff_7fff_7fff, 1'b0}, {48'h7fff_7fff_7fff, 1'b1}},
    '{{48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000},
      1'b1, {48'h8000_8000_8000, 1'b0}, {48'h8000_8000_8000, 1'b1}},
    '{{48'h7fff_7fff_7fff, 48'h8000_8000_8000, 48'h8000_8000_8000, 48'h7fff_7fff_7fff},
      1'b1, {48'h7fff_7fff_7fff, 1'b0}, {48'h7fff_7fff_7fff, 1'b1}},
    '{{48'h8000_8000_8000, 48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff, 48'h8000_8000_8000},
      1'b1, {48'h8000_8000_8000, 1'b0}, {48'h8000_8000_8000, 1'b1}},
    '{{48'hffff_ffff_ffff, 48'hffff_ffff_ffff, 48'hffff_ffff_ffff, 48'hffff_ffff_ffff},
      1'b1, {48'hffff_ffff_ffff, 1'b0}, {48'hffff_ffff_ffff, 1'b1}},
    '{{48'h7fff_8000_0000, 48'h8000_7fff_0001, 48'h7fff_0000_ffff, 48'h8000_ffff_7fff},
      1'b1, {48'h7fff_8000_0000, 1'b0}, {48'h8000_ffff_7fff, 1'b1}},
    '{{48'h0001_0001_0001, 48'h0001_0001_0001, 48'h0001_0001_0001, 48'h0001_0001_0001},
      1'b0, '0, '0},
    '{{48'h0000_0000_0000, 48'h7fff_7fff_7fff, 48'h0000_0000_0000, 48'h0000_0000_0000},
      1'b0, '0, '0},
    '{{48'h0000_0000_0000, 48'h0000_0000_0000, 48'h8000_8000_8000, 48'h0000_0000_0000},
      1'b0, '0, '0},
    '{{48'h8000_8000_8000, 48'h8000_8000_8000, 48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff},
      1'b0, '0, '0},
    '{{48'h5555_aaaa_5555, 48'haaaa_5555_aaaa, 48'h5555_aaaa_5555, 48'haaaa_5555_aaaa},
      1'b0, '0, '0},
    '{{48'h0000_0000_0000, 48'h1000_2000_3000, 48'h2000_4000_6000, 48'h3000_6000_9000},
      1'b0, '0, '0},
    '{{48'hffff_0001_ffff, 48'h0001_ffff_0001, 48'hffff_0001_ffff, 48'h0001_ffff_0001},
      1'b0, '0, '0},
    '{{48'h1234_edcb_0f0f, 48'hc0de_3fa5_7001, 48'h8001_0fff_f00f, 48'h4321_9abc_7ffe},
      1'b0, '0, '0}
  };

  int send_idle_by_phase [4] = '{0, 79, 0, 16};
  int stall_by_phase [4] = '{0, 0, 79, 16};

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   curve_valid = 1'b0;
  logic   curve_stall;
  curve_t curve = '0;
  logic   point_valid;
  logic   point_stall = 1'b0;
  point_t point;

  point_t pending_points [$];
  int     mismatch_count = 0;
  int     send_idle_pct = 0;
  int     stall_pct = 0;
  int     cycle_count = 0;

  cubic_bezier_tessellator #(
    .SEGMENTS(SEGS)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .curve_valid(curve_valid),
    .curve_stall(curve_stall),
    .curve      (curve),
    .point_valid(point_valid),
    .point_stall(point_stall),
    .point      (point)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // queues the SEGS+1 points of one curve: Bernstein weights in Q1.15,
  // Q5.27 sums rounded half up to Q4.12 and saturated
  function automatic void predict_points(input curve_t c);
    longint n, u, den, acc, r;
    longint w [4];
    longint p [12];
    logic [CoordW-1:0] coord [3];
    point_t pt;
    p = '{c.start_x, c.start_y, c.start_z, c.ctrl_one_x, c.ctrl_one_y, c.ctrl_one_z,
          c.ctrl_two_x, c.ctrl_two_y, c.ctrl_two_z, c.end_x, c.end_y, c.end_z};
    n = SEGS;
    den = n * n * n;
    for (int i = 0; i <= SEGS; i++) begin
      u = n - i;
      w[0] = u * u * u;
      w[1] = 3 * i * u * u;
      w[2] = 3 * i * i * u;
      w[3] = longint'(i) * i * i;
      for (int k = 0; k < 4; k++)
        w[k] = (w[k] * OneQ15 + den / 2) / den;
      for (int ax = 0; ax < 3; ax++) begin
        acc = 0;
        for (int k = 0; k < 4; k++)
          acc += w[k] * p[k * 3 + ax];
        r = (acc + 16384) >>> 15;
        if (r > 32767)
          r = 32767;
        if (r < -32768)
          r = -32768;
        coord[ax] = r[CoordW-1:0];
      end
      pt.point_x = coord[0];
      pt.point_y = coord[1];
      pt.point_z = coord[2];
      pt.final_point = (i == SEGS);
      pending_points.push_back(pt);
    end
  endfunction

  // called at a rising edge; returns at the edge of the transfer
  task automatic drive_curve(input curve_t c, input bit typed,
                             input point_t first_pt, input point_t last_pt);
    int base;
    while ($urandom_range(99) < send_idle_pct) begin
      curve_valid <= 1'b0;
      @(posedge clk);
    end
    curve_valid <= 1'b1;
    curve <= c;
    do @(posedge clk); while (curve_stall);
    base = pending_points.size();
    predict_points(c);
    if (typed) begin
      pending_points[base] = first_pt;
      pending_points[base + SEGS] = last_pt;
    end
  endtask

  always @(posedge clk) begin : point_check
    point_t want;
    if (rst) begin
      point_stall <= 1'b0;
    end else begin
      point_stall <= ($urandom_range(99) < stall_pct);
      if (point_valid && !point_stall) begin
        if (pending_points.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected point x=%0d y=%0d z=%0d last=%0b",
                     point.point_x, point.point_y, point.point_z, point.final_point);
        end else begin
          want = pending_points.pop_front();
          if (point.point_x !== want.point_x || point.point_y !== want.point_y ||
              point.point_z !== want.point_z || point.final_point !== want.final_point) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("point: expected x=%0d y=%0d z=%0d last=%0b, got x=%0d y=%0d z=%0d last=%0b",
                       want.point_x, want.point_y, want.point_z, want.final_point,
                       point.point_x, point.point_y, point.point_z, point.final_point);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cubic_bezier_tessellator: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    logic [11:0][CoordW-1:0] fields;
    int mode;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r])
      drive_curve(directed_rows[r].c, directed_rows[r].typed,
                  directed_rows[r].first_pt, directed_rows[r].last_pt);

    // hold off until every point of the directed curves is out
    curve_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        mode = $urandom_range(9);
        for (int f = 0; f < 12; f++) begin
          if (mode < 6) begin
            fields[f] = CoordW'($urandom);
          end else if (mode < 8) begin
            case ($urandom_range(5))
              0: fields[f] = 16'h8000;
              1: fields[f] = 16'h7fff;
              2: fields[f] = 16'h0000;
              3: fields[f] = 16'hffff;
              4: fields[f] = 16'h0001;
              default: fields[f] = CoordW'($urandom);
            endcase
          end else begin
            // small coordinates exercise rounding near zero
            fields[f] = CoordW'($urandom_range(1023) - 512);
          end
        end
        drive_curve(curve_t'(fields), 1'b0, '0, '0);
      end
    end

    curve_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("cubic_bezier_tessellator: match");
    else
      $display("cubic_bezier_tessellator: mismatch");
    $finish;
  end

endmodule

@@ sim.f @@
src/cbt_pkg.sv
src/cbt_seq.sv
src/cbt_lane.sv
src/cubic_bezier_tessellator.sv
src/cbt_checker.sv
verif/tb_cubic_bezier_tessellator.sv
